FILE: hw/rtl/stis_pkg.sv
// stis_pkg: shared widths, codes and control structs of the sorted key table
// used by the channel interfaces, the controller, the datapath and the top level
`default_nettype none

package stis_pkg;

    // fixed field widths
    localparam int KEY_W = 32;
    localparam int POS_W = 8;
    localparam int CNT_W = 9;
    localparam int CAP_W = 9;

    // register reset and default storage size
    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;
    localparam int DEPTH_DEFAULT = 256;

    // operation code of an input beat
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_SEARCH = 1'b1
    } t_action;

    // controller to datapath commands
    typedef struct packed {
        logic start;     // capture the beat and set up pointers
        logic rd_first;  // read the entry just below the insert pointer
        logic shift;     // move the read entry up one place
        logic put;       // write the new key and bump the count
        logic probe;     // read the midpoint of the search range
        logic narrow;    // drop the half that cannot hold the key
        logic hit;       // record a search match
        logic emit;      // load the output register
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic has_room;  // count below capacity and depth
        logic ptr_zero;  // insert pointer at the bottom
        logic gt;        // read entry above the key
        logic eq;        // read entry equals the key
        logic range_ok;  // search range not empty
        logic out_free;  // output register can take a beat
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: hw/rtl/stis_if.sv
// stis_in_if, stis_out_if: valid/ready channels for request and result beats
// depends on stis_pkg for field widths and the action code
`default_nettype none

interface stis_in_if import stis_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_action                 action;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink (input valid, input action, input key, output ready);
endinterface

interface stis_out_if import stis_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, output ok, output position, output entry_count,
                    input ready);
    modport sink (input valid, input ok, input position, input entry_count,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/stis_ctrl.sv
// stis_ctrl: sequencer for insert shifting and binary search probing
// depends on stis_pkg for the command and status structs
`default_nettype none

module stis_ctrl import stis_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_action   i_in_action,
    output logic           o_in_ready,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_FIRST,
        S_INS_SHIFT,
        S_SRCH_CHK,
        S_SRCH_CMP,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands, no beat taken while in reset
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.start = 1'b1;
                    if (i_in_action == ACT_SEARCH) begin
                        n_state = S_SRCH_CHK;
                    end else if (i_stat.has_room) begin
                        n_state = S_INS_FIRST;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_INS_FIRST: begin
                if (i_stat.ptr_zero) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_INS_SHIFT;
                end
            end
            S_INS_SHIFT: begin
                if (i_stat.ptr_zero || !i_stat.gt) begin
                    o_cmd.put = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_SRCH_CHK: begin
                if (i_stat.range_ok) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_SRCH_CMP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SRCH_CMP: begin
                if (i_stat.eq) begin
                    o_cmd.hit = 1'b1;
                    n_state   = S_FIN;
                end else begin
                    o_cmd.narrow = 1'b1;
                    n_state      = S_SRCH_CHK;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a result beat leaves only from the finishing state
    a_emit_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_FIN))
        else $error("emit outside finishing state");

    // after a beat is taken the controller is busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> !o_in_ready)
        else $error("ready right after accepting a beat");

    // a shift never runs with the pointer at the bottom
    a_no_shift_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.shift |-> !i_stat.ptr_zero)
        else $error("shift requested at position zero");

endmodule

`default_nettype wire

FILE: hw/rtl/stis_dp.sv
// stis_dp: key memory, insert pointer, search bounds, count and output register
// depends on stis_pkg for widths and the command and status structs
`default_nettype none

module stis_dp import stis_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [CAP_W-1:0]        i_cfg_wr_data,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire t_ctrl_cmd               i_cmd,
    output t_dp_stat                     o_stat,
    input  wire logic                    i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_out_ok,
    output logic [POS_W-1:0]             o_out_position,
    output logic [CNT_W-1:0]             o_out_entry_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int LW = CW + 1;
    localparam int WW = ((CW > CAP_W) ? CW : CAP_W) + 1;
    localparam int PW = (AW > POS_W) ? AW : POS_W;
    localparam int QW = (CW > CNT_W) ? CW : CNT_W;

    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

    logic [CAP_W-1:0]        r_cap;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_ptr;
    logic signed [LW-1:0]    r_low;
    logic signed [LW-1:0]    r_high;
    logic [AW-1:0]           r_mid;
    logic signed [KEY_W-1:0] r_key;
    logic signed [KEY_W-1:0] r_rd;
    logic                    r_ok;
    logic [AW-1:0]           r_pos;
    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [POS_W-1:0]        r_out_pos;
    logic [CNT_W-1:0]        r_out_cnt;

    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    logic signed [KEY_W-1:0] wr_data;
    logic [LW:0]             mid_sum;
    logic [AW-1:0]           mid;
    logic signed [LW-1:0]    mid_ext;
    logic [CW-1:0]           ptr_m1;
    logic [CW-1:0]           ptr_m2;
    logic [PW-1:0]           pos_ext;
    logic [QW-1:0]           cnt_ext;

    // midpoint of the search range, valid while the range is not empty
    assign mid_sum = {r_low[LW-1], r_low} + {r_high[LW-1], r_high};
    assign mid     = mid_sum[AW:1];
    assign mid_ext = LW'(r_mid);
    assign ptr_m1  = r_ptr - CW'(1);
    assign ptr_m2  = r_ptr - CW'(2);

    // status toward the controller
    always_comb begin
        o_stat.has_room = (WW'(r_count) < WW'(r_cap)) && (r_count < CW'(TABLE_DEPTH));
        o_stat.ptr_zero = (r_ptr == '0);
        o_stat.gt       = (r_rd > r_key);
        o_stat.eq       = (r_rd == r_key);
        o_stat.range_ok = (r_low <= r_high);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = ptr_m1[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_ptr[AW-1:0];
        wr_data = r_key;
        if (i_cmd.rd_first) begin
            rd_en = 1'b1;
        end
        if (i_cmd.shift) begin
            // prefetch the next entry down while this one moves up
            rd_en   = (r_ptr > CW'(1));
            rd_addr = ptr_m2[AW-1:0];
            wr_en   = 1'b1;
            wr_data = r_rd;
        end
        if (i_cmd.put) begin
            wr_en = 1'b1;
        end
        if (i_cmd.probe) begin
            rd_en   = 1'b1;
            rd_addr = mid;
        end
    end

    // key memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // working registers of one item
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key  <= i_key;
            r_ptr  <= r_count;
            r_low  <= '0;
            r_high <= LW'(r_count) - LW'(1);
            r_ok   <= 1'b0;
            r_pos  <= '0;
        end
        if (i_cmd.shift) begin
            r_ptr <= ptr_m1;
        end
        if (i_cmd.put) begin
            r_ok  <= 1'b1;
            r_pos <= r_ptr[AW-1:0];
        end
        if (i_cmd.probe) begin
            r_mid <= mid;
        end
        if (i_cmd.narrow) begin
            if (r_key > r_rd) begin
                r_low <= mid_ext + LW'(1);
            end else begin
                r_high <= mid_ext - LW'(1);
            end
        end
        if (i_cmd.hit) begin
            r_ok  <= 1'b1;
            r_pos <= r_mid;
        end
    end

    // capacity register and entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // result fields wrap to the port widths
    assign pos_ext = PW'(r_pos);
    assign cnt_ext = QW'(r_count);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ok  <= r_ok;
            r_out_pos <= pos_ext[POS_W-1:0];
            r_out_cnt <= cnt_ext[CNT_W-1:0];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_ok          = r_out_ok;
    assign o_out_position    = r_out_pos;
    assign o_out_entry_count = r_out_cnt;

    // the table never holds more than its depth
    a_count_in_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // a new key only lands while the count is below the capacity
    a_put_under_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> (WW'(r_count) < WW'(r_cap)))
        else $error("insert beyond capacity");

    // the count moves only when a key is written in
    a_count_only_on_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(i_cmd.put))
        else $error("entry count changed without an insert");

    // a beat is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_out_valid) |-> i_out_ready)
        else $error("output register overwritten");

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_table_insert_search.sv
// sorted_table_insert_search: top level joining controller and datapath
// depends on stis_pkg, stis_if, stis_ctrl and stis_dp
`default_nettype none

// Keeps up to TABLE_DEPTH signed 32-bit keys in ascending order in a single-port-write,
// registered-read memory. An insert beat is refused when the entry count has reached
// the smaller of the capacity register and TABLE_DEPTH; otherwise entries above the
// key move up one place and the key lands after any equal keys. The shift loop reads
// one entry and writes it one place up each cycle. A search beat runs a binary
// search in which each probe reads the midpoint from memory, then compares it.
// One item is worked on at a time; a new beat is taken as soon as the previous
// result sits in the output register, even while that result is still waiting on
// the sink. The capacity register must be written only while idle; the block itself
// has no check for this. The memory needs no clearing after reset: only entries
// below the count are read.

module sorted_table_insert_search import stis_pkg::*; #(
    parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CAP_W-1:0] i_cfg_wr_data,
    stis_in_if.sink               i_in,
    stis_out_if.source            o_out
);

    t_ctrl_cmd cmd;
    t_dp_stat  stat;

    // sequencer
    stis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage and arithmetic
    stis_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_key             (i_in.key),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_out_ok          (o_out.ok),
        .o_out_position    (o_out.position),
        .o_out_entry_count (o_out.entry_count)
    );

endmodule

`default_nettype wire
